// ----- sv/positional_ordered_list_defines.svh -----
// ----------------------------------------------------------------------------
// positional_ordered_list_defines: assertion macros
// Concurrent check macros shared by the list block; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_ORDERED_LIST_DEFINES_SVH
`define POSITIONAL_ORDERED_LIST_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define POL_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("list check failed: same-cycle implication");

// next-cycle implication
`define POL_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("list check failed: next-cycle implication");

`else

`define POL_ASSERT_IMP(label, clk, rst, a, c)
`define POL_ASSERT_NEXT(label, clk, rst, a, c)

`endif

`endif

// ----- sv/pol_pkg.sv -----
// ----------------------------------------------------------------------------
// pol_pkg: shared definitions for the positional ordered list
// Operation and status codes, cell control word and controller states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pol_pkg;

  // operation codes
  localparam logic [2:0] OP_INSERT   = 3'd0;
  localparam logic [2:0] OP_REMOVE   = 3'd1;
  localparam logic [2:0] OP_GET      = 3'd2;
  localparam logic [2:0] OP_SET      = 3'd3;
  localparam logic [2:0] OP_FIND     = 3'd4;
  localparam logic [2:0] OP_TRAV_FWD = 3'd5;
  localparam logic [2:0] OP_TRAV_REV = 3'd6;

  // status codes
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_BOUNDS   = 2'd1;
  localparam logic [1:0] STAT_NOTFOUND = 2'd2;
  localparam logic [1:0] STAT_FULL     = 2'd3;

  // cell index width, wide enough for the largest supported row
  localparam int POS_W = 6;

  // control word broadcast to every cell
  typedef struct packed {
    logic             ins;
    logic             rem;
    logic             set;
    logic [POS_W-1:0] pos;
  } pol_cell_ctrl_t;

  typedef enum logic {
    S_IDLE,
    S_TRAV
  } pol_state_t;

endpackage

// ----- sv/pol_cell.sv -----
// ----------------------------------------------------------------------------
// pol_cell: one list entry
// Holds one word, takes it from a neighbor on insert or remove shifts,
// loads the new word on insert or set, and compares it for find.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pol_cell
  import pol_pkg::*;
#(
  parameter int DATA_WIDTH = 32,
  parameter int IDX        = 0
) (
  input  logic                  clk,
  input  pol_cell_ctrl_t        ctrl,
  input  logic [DATA_WIDTH-1:0] value,
  input  logic [DATA_WIDTH-1:0] left_data,
  input  logic [DATA_WIDTH-1:0] right_data,
  output logic [DATA_WIDTH-1:0] data,
  output logic                  match
);

  localparam logic [POS_W-1:0] MY_POS = POS_W'(IDX);

  logic at_pos;
  logic above_pos;

  assign at_pos    = (ctrl.pos == MY_POS);
  assign above_pos = (MY_POS > ctrl.pos);

  // load, shift up, shift down or hold
  always_ff @(posedge clk) begin
    if ((ctrl.ins || ctrl.set) && at_pos) begin
      data <= value;
    end else if (ctrl.ins && above_pos) begin
      data <= left_data;
    end else if (ctrl.rem && (above_pos || at_pos)) begin
      data <= right_data;
    end
  end

  // compare for find
  assign match = (data == value);

endmodule

// ----- sv/positional_ordered_list.sv -----
// ----------------------------------------------------------------------------
// positional_ordered_list: bounded ordered list in a row of cells
// Insert, remove, get, set, find and traverse over up to DEPTH words.
// ----------------------------------------------------------------------------
// Insert, remove, get, set and find load the result word into the output
//   register at the accepting edge, one item per cycle unless out_stall holds.
// Traverse sets up index and direction, then streams one word per cycle from
//   the read mux unless out_stall holds; input stalls until the last word loads.
// Reset clears the length and the controller; entry words are not cleared.
`timescale 1ns / 1ps

`include "positional_ordered_list_defines.svh"

module positional_ordered_list
  import pol_pkg::*;
#(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [2:0]            operation,
  input  logic [4:0]            position,
  input  logic [DATA_WIDTH-1:0] value,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            status,
  output logic [DATA_WIDTH-1:0] item_value,
  output logic [4:0]            number,
  output logic                  item_valid,
  output logic                  last
);

  localparam int IW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW   = $clog2(DEPTH + 1);
  localparam int CMPW = (LW > 5) ? LW : 5;

  pol_state_t            state;
  pol_state_t            state_next;
  logic [LW-1:0]         len;
  logic [LW-1:0]         len_next;
  logic [IW-1:0]         idx;
  logic                  trav_rev;
  logic                  trav_start;
  logic                  trav_adv;
  logic                  trav_last;
  logic [IW-1:0]         trav_addr;
  logic [IW-1:0]         rd_addr;
  logic [DATA_WIDTH-1:0] rd_data;

  logic                  acc;
  logic                  out_load;
  logic [CMPW-1:0]       pos_ext;
  logic [CMPW-1:0]       len_ext;
  logic [IW-1:0]         pos_idx;

  pol_cell_ctrl_t        ctrl;
  logic [DATA_WIDTH-1:0] cell_data [DEPTH];
  logic [DEPTH-1:0]      match;
  logic [DEPTH-1:0]      hit;
  logic                  found;
  logic [IW-1:0]         found_idx;

  logic                  res_load;
  logic [1:0]            res_status;
  logic [DATA_WIDTH-1:0] res_value;
  logic [4:0]            res_number;
  logic                  res_ivalid;
  logic                  res_last;

  // handshake
  assign out_load = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE) || !out_load;
  assign acc      = in_valid && !in_stall;

  assign pos_ext = CMPW'(position);
  assign len_ext = CMPW'(len);
  assign pos_idx = pos_ext[IW-1:0];

  // row of cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_in;
    logic [DATA_WIDTH-1:0] right_in;

    if (i == 0) begin : g_head
      assign left_in = '0;
    end else begin : g_left
      assign left_in = cell_data[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_in = cell_data[i];
    end else begin : g_right
      assign right_in = cell_data[i+1];
    end

    pol_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .IDX        (i)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .value      (value),
      .left_data  (left_in),
      .right_data (right_in),
      .data       (cell_data[i]),
      .match      (match[i])
    );

    assign hit[i] = match[i] && (LW'(i) < len);
  end

  // first matching position
  always_comb begin
    found     = 1'b0;
    found_idx = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (hit[i]) begin
        found     = 1'b1;
        found_idx = IW'(i);
      end
    end
  end

  // read port for get and traverse
  assign trav_addr = trav_rev ? IW'(len - LW'(1) - LW'(idx)) : idx;
  assign trav_last = ((LW'(idx) + LW'(1)) == len);
  assign rd_addr   = (state == S_TRAV) ? trav_addr : pos_idx;
  assign rd_data   = cell_data[rd_addr];

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (acc && (operation == OP_TRAV_FWD || operation == OP_TRAV_REV) &&
            (len != '0)) begin
          state_next = S_TRAV;
        end
      end
      S_TRAV: begin
        if (out_load && trav_last) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // decode operation, drive cells and result word
  always_comb begin
    res_load   = 1'b0;
    res_status = STAT_OK;
    res_value  = '0;
    res_number = '0;
    res_ivalid = 1'b0;
    res_last   = 1'b1;
    ctrl       = '0;
    ctrl.pos   = POS_W'(pos_idx);
    len_next   = len;
    trav_start = 1'b0;
    trav_adv   = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (acc) begin
          res_load = 1'b1;
          unique case (operation) inside
            OP_INSERT: begin
              if (pos_ext > len_ext) begin
                res_status = STAT_BOUNDS;
              end else if (len == LW'(DEPTH)) begin
                res_status = STAT_FULL;
              end else begin
                ctrl.ins = 1'b1;
                len_next = len + LW'(1);
              end
            end
            OP_REMOVE: begin
              if (pos_ext >= len_ext) begin
                res_status = STAT_BOUNDS;
              end else begin
                ctrl.rem = 1'b1;
                len_next = len - LW'(1);
              end
            end
            OP_GET: begin
              if (pos_ext >= len_ext) begin
                res_status = STAT_BOUNDS;
              end else begin
                res_value  = rd_data;
                res_ivalid = 1'b1;
              end
            end
            OP_SET: begin
              if (pos_ext >= len_ext) begin
                res_status = STAT_BOUNDS;
              end else begin
                ctrl.set = 1'b1;
              end
            end
            OP_FIND: begin
              if (found) begin
                res_number = 5'(found_idx);
              end else begin
                res_status = STAT_NOTFOUND;
              end
            end
            OP_TRAV_FWD, OP_TRAV_REV: begin
              // empty list gives one marked word, else start streaming
              if (len != '0) begin
                res_load   = 1'b0;
                trav_start = 1'b1;
              end
            end
            default: res_status = STAT_BOUNDS;
          endcase
        end
      end
      S_TRAV: begin
        if (out_load) begin
          res_load   = 1'b1;
          res_value  = rd_data;
          res_number = 5'(idx);
          res_ivalid = 1'b1;
          res_last   = trav_last;
          trav_adv   = 1'b1;
        end
      end
      default: res_load = 1'b0;
    endcase
  end

  // controller state and length
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      len   <= '0;
    end else begin
      state <= state_next;
      len   <= len_next;
    end
  end

  // traverse index and direction
  always_ff @(posedge clk) begin
    if (trav_start) begin
      idx      <= '0;
      trav_rev <= (operation == OP_TRAV_REV);
    end else if (trav_adv) begin
      idx <= idx + IW'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= res_load;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && res_load) begin
      status     <= res_status;
      item_value <= res_value;
      number     <= res_number;
      item_valid <= res_ivalid;
      last       <= res_last;
    end
  end

  // checks
  `POL_ASSERT_IMP(a_len_bound, clk, rst, 1'b1, len <= LW'(DEPTH))
  `POL_ASSERT_NEXT(a_insert_grows, clk, rst, acc && ctrl.ins, len == $past(len) + LW'(1))
  `POL_ASSERT_NEXT(a_trav_ends, clk, rst, (state == S_TRAV) && trav_adv && trav_last, (state == S_IDLE) && out_valid && last)
  `POL_ASSERT_NEXT(a_trav_stream, clk, rst, (state == S_TRAV) && trav_adv && !trav_last, out_valid && !last && item_valid)

endmodule

// ----- sim/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: testbench for the positional ordered list
// Drives insert, remove, get, set, find and traverse words into the list,
// keeps a shadow row of cells to predict every result word, and compares
// each accepted result field by field against the oldest prediction.
// Both channels idle in random bursts, except in the closing stretch.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import pol_pkg::*;

  localparam int DEPTH = 16;
  localparam int DATA_WIDTH = 32;
  localparam logic [2:0] OP_UNUSED = 3'd7;
  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE_CYCLES = 24;

  typedef struct packed {
    logic [1:0]            status;
    logic [DATA_WIDTH-1:0] item_value;
    logic [4:0]            number;
    logic                  item_valid;
    logic                  last;
  } list_result_t;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_stall;
  logic [2:0]            operation;
  logic [4:0]            position;
  logic [DATA_WIDTH-1:0] value;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [1:0]            status;
  logic [DATA_WIDTH-1:0] item_value;
  logic [4:0]            number;
  logic                  item_valid;
  logic                  last;

  // shadow copy of the list contents
  logic [DATA_WIDTH-1:0] shadow_cells [DEPTH];
  int                    shadow_len;
  list_result_t          pending_results [$];

  int errors;
  int cycle_count;
  bit idle_enable;
  int out_burst;

  positional_ordered_list #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .operation  (operation),
    .position   (position),
    .value      (value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .item_value (item_value),
    .number     (number),
    .item_valid (item_valid),
    .last       (last)
  );

  // 12 ns clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Queue one predicted result word
  function automatic void push_result(logic [1:0] st, logic [DATA_WIDTH-1:0] word,
                                      logic [4:0] num, logic vld, logic fin);
    list_result_t r;
    r.status     = st;
    r.item_value = word;
    r.number     = num;
    r.item_valid = vld;
    r.last       = fin;
    pending_results.push_back(r);
  endfunction

  // Apply one accepted operation to the shadow list and predict its results
  function automatic void predict_list_op(logic [2:0] op, logic [4:0] pos,
                                          logic [DATA_WIDTH-1:0] val);
    int  p;
    int  i;
    int  src_idx;
    bit  hit;
    p   = int'(pos);
    hit = 1'b0;
    case (op)
      OP_INSERT: begin
        if (p > shadow_len) begin
          push_result(STAT_BOUNDS, '0, '0, 1'b0, 1'b1);
        end else if (shadow_len >= DEPTH) begin
          push_result(STAT_FULL, '0, '0, 1'b0, 1'b1);
        end else begin
          // shift the tail up by one cell
          for (i = shadow_len; i > p; i--) shadow_cells[i] = shadow_cells[i-1];
          shadow_cells[p] = val;
          shadow_len++;
          push_result(STAT_OK, '0, '0, 1'b0, 1'b1);
        end
      end
      OP_REMOVE: begin
        if (p >= shadow_len) begin
          push_result(STAT_BOUNDS, '0, '0, 1'b0, 1'b1);
        end else begin
          for (i = p; i + 1 < shadow_len; i++) shadow_cells[i] = shadow_cells[i+1];
          shadow_len--;
          push_result(STAT_OK, '0, '0, 1'b0, 1'b1);
        end
      end
      OP_GET: begin
        if (p >= shadow_len) push_result(STAT_BOUNDS, '0, '0, 1'b0, 1'b1);
        else push_result(STAT_OK, shadow_cells[p], '0, 1'b1, 1'b1);
      end
      OP_SET: begin
        if (p >= shadow_len) begin
          push_result(STAT_BOUNDS, '0, '0, 1'b0, 1'b1);
        end else begin
          shadow_cells[p] = val;
          push_result(STAT_OK, '0, '0, 1'b0, 1'b1);
        end
      end
      OP_FIND: begin
        // report the first matching cell only
        for (i = 0; i < shadow_len; i++) begin
          if (!hit && shadow_cells[i] == val) begin
            push_result(STAT_OK, '0, 5'(i), 1'b0, 1'b1);
            hit = 1'b1;
          end
        end
        if (!hit) push_result(STAT_NOTFOUND, '0, '0, 1'b0, 1'b1);
      end
      OP_TRAV_FWD, OP_TRAV_REV: begin
        if (shadow_len == 0) begin
          push_result(STAT_OK, '0, '0, 1'b0, 1'b1);
        end else begin
          for (i = 0; i < shadow_len; i++) begin
            src_idx = (op == OP_TRAV_FWD) ? i : shadow_len - 1 - i;
            push_result(STAT_OK, shadow_cells[src_idx], 5'(i), 1'b1,
                        i == shadow_len - 1);
          end
        end
      end
      default: begin
        push_result(STAT_BOUNDS, '0, '0, 1'b0, 1'b1);
      end
    endcase
  endfunction

  // Random words half the time, with the extremes and small values mixed in
  function automatic logic [DATA_WIDTH-1:0] pick_word();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return DATA_WIDTH'($urandom_range(0, 15));
      default: return DATA_WIDTH'($urandom);
    endcase
  endfunction

  // Send one word, with an optional gap, and predict on acceptance
  task automatic send_word(logic [2:0] op, logic [4:0] pos, logic [DATA_WIDTH-1:0] val);
    int gap;
    if (idle_enable && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 17);
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid  = 1'b1;
    operation = op;
    position  = pos;
    value     = val;
    do @(posedge clk); while (in_stall);
    predict_list_op(op, pos, val);
  endtask

  // Hold the input idle until every predicted result has arrived
  task automatic wait_results_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Every operation on an empty list, plus the unused opcode
  task automatic test_empty_list();
    send_word(OP_TRAV_FWD, 5'd0, '0);
    send_word(OP_TRAV_REV, 5'd31, '1);
    send_word(OP_GET, 5'd0, '0);
    send_word(OP_REMOVE, 5'd0, '0);
    send_word(OP_SET, 5'd0, 32'h1234_5678);
    send_word(OP_FIND, 5'd0, '0);
    send_word(OP_INSERT, 5'd1, 32'hDEAD_BEEF);
    send_word(OP_UNUSED, 5'd31, '1);
  endtask

  // Head, tail and middle inserts, then traversals, reads, writes, finds and removes
  task automatic test_head_and_tail();
    send_word(OP_INSERT, 5'd0, 32'hFFFF_FFFF);
    send_word(OP_INSERT, 5'd0, 32'h0000_0000);
    send_word(OP_INSERT, 5'd2, 32'hA5A5_A5A5);
    send_word(OP_INSERT, 5'd1, 32'h5A5A_5A5A);
    send_word(OP_TRAV_FWD, 5'd0, '0);
    send_word(OP_TRAV_REV, 5'd0, '0);
    send_word(OP_GET, 5'd0, '0);
    send_word(OP_GET, 5'd3, '0);
    send_word(OP_GET, 5'd4, '0);
    send_word(OP_SET, 5'd3, 32'h8000_0001);
    send_word(OP_FIND, 5'd0, 32'hFFFF_FFFF);
    send_word(OP_FIND, 5'd0, 32'h0000_0000);
    send_word(OP_REMOVE, 5'd0, '0);
    send_word(OP_REMOVE, 5'd2, '0);
    send_word(OP_REMOVE, 5'd5, '0);
  endtask

  // Fill the list, then hit the full and bounds checks at capacity
  task automatic test_full_list();
    while (shadow_len < DEPTH)
      send_word(OP_INSERT, 5'($urandom_range(0, shadow_len)), pick_word());
    send_word(OP_INSERT, 5'd16, pick_word());
    send_word(OP_INSERT, 5'd17, pick_word());
    send_word(OP_INSERT, 5'd0, pick_word());
    send_word(OP_TRAV_FWD, 5'd0, '0);
    send_word(OP_TRAV_REV, 5'd0, '0);
    send_word(OP_GET, 5'd15, '0);
    send_word(OP_GET, 5'd16, '0);
    send_word(OP_FIND, 5'd0, shadow_cells[DEPTH-1]);
    send_word(OP_REMOVE, 5'd15, '0);
    send_word(OP_REMOVE, 5'd0, '0);
    wait_results_drained();
  endtask

  // Random mix that swings the length between empty and full
  task automatic test_random_mix(int n_items);
    logic [2:0]            op;
    logic [4:0]            pos;
    logic [DATA_WIDTH-1:0] val;
    bit                    grow;
    int                    r;
    int                    ins_w;
    grow = 1'b1;
    repeat (n_items) begin
      if (shadow_len == DEPTH) grow = 1'b0;
      else if (shadow_len == 0) grow = 1'b1;
      else if ($urandom_range(0, 39) == 0) grow = !grow;
      ins_w = grow ? 35 : 15;
      r = $urandom_range(0, 99);
      if (r < ins_w) op = OP_INSERT;
      else if (r < 50) op = OP_REMOVE;
      else if (r < 62) op = OP_GET;
      else if (r < 72) op = OP_SET;
      else if (r < 84) op = OP_FIND;
      else if (r < 92) op = OP_TRAV_FWD;
      else if (r < 98) op = OP_TRAV_REV;
      else op = OP_UNUSED;
      // mostly legal positions, some anywhere in the field
      if ($urandom_range(0, 9) == 0 || op == OP_FIND || op == OP_TRAV_FWD ||
          op == OP_TRAV_REV || op == OP_UNUSED)
        pos = 5'($urandom_range(0, 31));
      else if (op == OP_INSERT)
        pos = 5'($urandom_range(0, shadow_len));
      else
        pos = (shadow_len == 0) ? 5'd0 : 5'($urandom_range(0, shadow_len - 1));
      val = pick_word();
      if (op == OP_FIND && shadow_len > 0 && $urandom_range(0, 1) == 1)
        val = shadow_cells[$urandom_range(0, shadow_len - 1)];
      send_word(op, pos, val);
    end
  endtask

  // Stall the result side in random bursts
  always @(negedge clk) begin
    if (out_burst > 0) begin
      out_stall = 1'b1;
      out_burst--;
    end else if (idle_enable && $urandom_range(0, 9) == 0) begin
      out_stall = 1'b1;
      out_burst = $urandom_range(1, 17) - 1;
    end else begin
      out_stall = 1'b0;
    end
  end

  function automatic void check_field(string name, logic [DATA_WIDTH-1:0] want,
                                      logic [DATA_WIDTH-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
      errors++;
    end
  endfunction

  // Compare each accepted result word with the oldest prediction
  always @(posedge clk) begin
    list_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, got status %0d value %h number %0d",
                 $time, status, item_value, number);
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", DATA_WIDTH'(want.status), DATA_WIDTH'(status));
        check_field("item_value", want.item_value, item_value);
        check_field("number", DATA_WIDTH'(want.number), DATA_WIDTH'(number));
        check_field("item_valid", DATA_WIDTH'(want.item_valid), DATA_WIDTH'(item_valid));
        check_field("last", DATA_WIDTH'(want.last), DATA_WIDTH'(last));
      end
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
      $display("** positional_ordered_list: FAILED **");
      $finish;
    end
  end

  initial begin
    rst         = 1'b1;
    in_valid    = 1'b0;
    operation   = OP_INSERT;
    position    = '0;
    value       = '0;
    errors      = 0;
    cycle_count = 0;
    out_burst   = 0;
    shadow_len  = 0;
    idle_enable = 1'b1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_empty_list();
    test_head_and_tail();
    test_full_list();
    test_random_mix(290);
    // closing stretch runs at full rate on both sides
    idle_enable = 1'b0;
    test_random_mix(75);

    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("** positional_ordered_list: PASSED **");
    end else begin
      $display("** positional_ordered_list: FAILED **");
    end
    $finish;
  end

endmodule
